// File: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AZLF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AZLF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/azlf_pkg.sv
package azlf_pkg;

    localparam int MAX_ORDER = 16;

    localparam int ORDER_W  = 5;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int STAGE_W  = 24;
    localparam int FRAC_W   = 15;

    localparam int DL_AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CT_AW  = $clog2(MAX_ORDER + 1);
    localparam int PROD_W = COEF_W + STAGE_W;
    localparam int QM_W   = PROD_W - FRAC_W;

    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int STAGE_MAX  = (1 << (STAGE_W - 1)) - 1;
    localparam int STAGE_MIN  = -(1 << (STAGE_W - 1));
    localparam int OUT_MAX    = (1 << (SAMPLE_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STAGE_W-1:0]  stage_t;
    typedef logic signed [QM_W-1:0]     qprod_t;
    typedef logic signed [QM_W:0]       wide_t;
    typedef logic [ORDER_W-1:0]         order_t;
    typedef logic [DL_AW-1:0]           dl_addr_t;
    typedef logic [CT_AW-1:0]           ct_addr_t;

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_COEF   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic     wr_en;
        ct_addr_t wr_addr;
        coef_t    wr_data;
        ct_addr_t rd_addr;
    } coef_port_t;

    typedef struct packed {
        logic     clear;
        logic     wr_en;
        dl_addr_t wr_addr;
        stage_t   wr_data;
        dl_addr_t rd_addr;
    } delay_port_t;

    typedef struct packed {
        qprod_t prod_ks;
        stage_t fwd;
        stage_t sum;
        logic   clip;
    } alu_res_t;

    typedef struct packed {
        stage_t val;
        logic   clip;
    } stage_sat_t;

    typedef struct packed {
        sample_t val;
        logic    clip;
    } out_sat_t;

    // Q3.15 coefficient times integer, rounded half up, floor shift
    function automatic qprod_t qmul(coef_t k, stage_t v);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(k) * PROD_W'(v);
        p = p + PROD_W'(ROUND_HALF);
        return qprod_t'(p[PROD_W-1:FRAC_W]);
    endfunction

    function automatic stage_sat_t sat_stage(wide_t v);
        stage_sat_t r;
        r.clip = 1'b1;
        if (v > (QM_W+1)'(STAGE_MAX)) begin
            r.val = stage_t'(STAGE_MAX);
        end else if (v < (QM_W+1)'(STAGE_MIN)) begin
            r.val = stage_t'(STAGE_MIN);
        end else begin
            r.val  = v[STAGE_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    function automatic out_sat_t sat_out(qprod_t v);
        out_sat_t r;
        r.clip = 1'b1;
        if (v > QM_W'(OUT_MAX)) begin
            r.val = sample_t'(OUT_MAX);
        end else if (v < QM_W'(OUT_MIN)) begin
            r.val = sample_t'(OUT_MIN);
        end else begin
            r.val  = v[SAMPLE_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/azlf_coef_store.sv
module azlf_coef_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  azlf_pkg::coef_port_t  port,
    output azlf_pkg::coef_t       rd_coef
);
    import azlf_pkg::*;

    coef_t              mem [MAX_ORDER+1];
    logic [MAX_ORDER:0] valid_reg;
    coef_t              rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (port.wr_en) begin
            mem[port.wr_addr] <= port.wr_data;
        end
        rd_data_reg <= mem[port.rd_addr];
    end

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (port.wr_en) begin
                valid_reg[port.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[port.rd_addr];
        end
    end

    assign rd_coef = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/azlf_delay_store.sv
module azlf_delay_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  azlf_pkg::delay_port_t  port,
    output azlf_pkg::stage_t       rd_data
);
    import azlf_pkg::*;

    stage_t               mem [MAX_ORDER];
    logic [MAX_ORDER-1:0] valid_reg;
    stage_t               rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (port.wr_en) begin
            mem[port.wr_addr] <= port.wr_data;
        end
        rd_data_reg <= mem[port.rd_addr];
    end

    // clear drops every entry back to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (port.clear) begin
                valid_reg <= '0;
            end else if (port.wr_en) begin
                valid_reg[port.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[port.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/azlf_stage_alu.sv
module azlf_stage_alu (
    input  azlf_pkg::coef_t    k,
    input  azlf_pkg::stage_t   d,
    input  azlf_pkg::stage_t   sum,
    output azlf_pkg::alu_res_t res
);
    import azlf_pkg::*;

    qprod_t     prod_ks;
    qprod_t     prod_kd;
    stage_sat_t fwd_sat;
    stage_sat_t sum_sat;

    always_comb begin
        prod_ks = qmul(k, sum);
        prod_kd = qmul(k, d);
        fwd_sat = sat_stage((QM_W+1)'(d) + (QM_W+1)'(prod_ks));
        sum_sat = sat_stage((QM_W+1)'(sum) + (QM_W+1)'(prod_kd));

        res.prod_ks = prod_ks;  // also the gain product in the last step
        res.fwd     = fwd_sat.val;
        res.sum     = sum_sat.val;
        res.clip    = fwd_sat.clip | sum_sat.clip;
    end

endmodule

// File: rtl/all_zero_lattice_filter.sv
// Filter transfer: RUN stages (none at order 0), then the GAIN step; ready returns
// as the result turns valid; one stage per cycle through the shared multiplier pair.
// Coefficient transfer: leaves the block ready, no result.
// Result register frees the input side; a stalled result holds only the final gain step.
// aresetn (sync, active low): order 16, coefficients and delay line read as zero
// through per-entry valid bits, no clearing pass.
module all_zero_lattice_filter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  azlf_pkg::order_t      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  azlf_pkg::sample_t     s_sample_in,
    input  azlf_pkg::order_t      s_coef_index,
    input  azlf_pkg::coef_t       s_coef_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output azlf_pkg::sample_t     m_sample_out,
    output logic                  m_saturated
);
    import azlf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_GAIN = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    order_t      order_reg;
    dl_addr_t    stage_reg;
    stage_t      sum_reg;
    stage_t      back_reg;
    logic        sat_reg;
    sample_t     out_sample_reg;
    logic        out_sat_reg;
    logic        m_valid_reg;

    coef_port_t  coef_port;
    delay_port_t delay_port;
    coef_t       k_rd;
    stage_t      d_rd;
    alu_res_t    alu;
    out_sat_t    y_sat;

    logic        accept;
    logic        last_stage;
    logic        out_load;

    assign accept     = s_valid && s_ready;
    assign last_stage = (ORDER_W'(stage_reg) + ORDER_W'(1)) == order_reg;
    assign out_load   = (state_reg == ST_GAIN) && (!m_valid_reg || m_ready);
    assign y_sat      = sat_out(alu.prod_ks);

    always_comb begin
        coef_port.wr_en   = accept && (s_command == CMD_COEF)
                            && ({1'b0, s_coef_index} <= (ORDER_W+1)'(MAX_ORDER));
        coef_port.wr_addr = CT_AW'(s_coef_index);
        coef_port.wr_data = s_coef_value;

        delay_port.clear   = cfg_we;
        delay_port.wr_en   = (state_reg == ST_RUN);
        delay_port.wr_addr = stage_reg;
        delay_port.wr_data = back_reg;

        // reads are addressed in the cycle before the stage that uses them
        unique case (state_reg)
            ST_IDLE: begin
                coef_port.rd_addr  = (order_reg != '0) ? CT_AW'(1) : '0;
                delay_port.rd_addr = '0;
            end
            ST_RUN: begin
                coef_port.rd_addr  = last_stage ? '0 : CT_AW'(stage_reg) + CT_AW'(2);
                delay_port.rd_addr = stage_reg + DL_AW'(1);
            end
            ST_GAIN: begin
                coef_port.rd_addr  = '0;
                delay_port.rd_addr = stage_reg;
            end
            default: begin
                coef_port.rd_addr  = '0;
                delay_port.rd_addr = '0;
            end
        endcase
    end

    azlf_coef_store u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .port    (coef_port),
        .rd_coef (k_rd)
    );

    azlf_delay_store u_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .port    (delay_port),
        .rd_data (d_rd)
    );

    azlf_stage_alu u_alu (
        .k   (k_rd),
        .d   (d_rd),
        .sum (sum_reg),
        .res (alu)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_command == CMD_FILTER)) begin
                    state_next = (order_reg != '0) ? ST_RUN : ST_GAIN;
                end
            end
            ST_RUN: begin
                if (last_stage) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            order_reg   <= ORDER_W'(MAX_ORDER);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                order_reg <= (cfg_wdata > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                               : cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            sum_reg   <= stage_t'(s_sample_in);
            back_reg  <= stage_t'(s_sample_in);
            sat_reg   <= 1'b0;
            stage_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            sum_reg   <= alu.sum;
            back_reg  <= alu.fwd;
            sat_reg   <= sat_reg | alu.clip;
            if (!last_stage) begin
                stage_reg <= stage_reg + DL_AW'(1);
            end
        end
        if (out_load) begin
            out_sample_reg <= y_sat.val;
            out_sat_reg    <= sat_reg | y_sat.clip;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_saturated  = out_sat_reg;

endmodule

// File: rtl/azlf_checker.sv
`include "assert_macros.svh"

module azlf_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  s_command,
    input logic                  m_valid,
    input logic                  m_ready,
    input azlf_pkg::sample_t     m_sample_out,
    input logic                  m_saturated
);
    import azlf_pkg::*;

    // a stalled result keeps its value
    `AZLF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_sample_out) && $stable(m_saturated),
        "result changed while stalled")

    // no result appears right after any input transfer
    `AZLF_ASSERT_NXT(a_no_early_result, aclk, aresetn, s_valid && s_ready,
        !$rose(m_valid), "result too early after input transfer")

    // a filter transfer occupies the block
    `AZLF_ASSERT_NXT(a_busy_after_filter, aclk, aresetn,
        s_valid && s_ready && (s_command == CMD_FILTER), !s_ready,
        "ready high right after filter transfer")

    // a coefficient transfer leaves the block ready
    `AZLF_ASSERT_NXT(a_coef_one_cycle, aclk, aresetn,
        s_valid && s_ready && (s_command == CMD_COEF), s_ready,
        "not ready after coefficient transfer")

endmodule

bind all_zero_lattice_filter azlf_checker u_azlf_checker (.*);

// File: test/all_zero_lattice_filter_test.sv
module all_zero_lattice_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import azlf_pkg::*;

    localparam int ITEM_GOAL   = 1350;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int COEF_MAX    = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN    = -(1 << (COEF_W - 1));
    localparam int UNITY       = 1 << FRAC_W;

    class lattice_scoreboard;
        stage_t      taps[MAX_ORDER];
        coef_t       kcoef[MAX_ORDER + 1];
        int unsigned stages;
        sample_t     pending_out[$];
        bit          pending_sat[$];
        int          mismatches;

        function new();
            foreach (kcoef[i]) begin
                kcoef[i] = '0;
            end
            set_order(order_t'(MAX_ORDER));
            mismatches = 0;
        endfunction

        function void set_order(order_t v);
            stages = (v > MAX_ORDER) ? MAX_ORDER : v;
            foreach (taps[i]) begin
                taps[i] = '0;
            end
        endfunction

        function int pending();
            return pending_out.size();
        endfunction

        // Q3.15 times integer, round half up, floor shift
        function longint round_mul(coef_t k, longint v);
            return (longint'(k) * v + (1 << (FRAC_W - 1))) >>> FRAC_W;
        endfunction

        function longint clamp(longint v, longint lo, longint hi, inout bit clipped);
            if (v > hi) begin
                clipped = 1'b1;
                return hi;
            end
            if (v < lo) begin
                clipped = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function void filter_sample(sample_t x);
            longint acc, back, fwd, d, y;
            bit     clipped;
            clipped = 1'b0;
            acc  = x;
            back = x;
            for (int m = 0; m < stages; m++) begin
                d    = taps[m];
                fwd  = clamp(d + round_mul(kcoef[m + 1], acc), STAGE_MIN, STAGE_MAX, clipped);
                acc  = clamp(acc + round_mul(kcoef[m + 1], d), STAGE_MIN, STAGE_MAX, clipped);
                taps[m] = stage_t'(back);
                back = fwd;
            end
            y = clamp(round_mul(kcoef[0], acc), OUT_MIN, OUT_MAX, clipped);
            pending_out.push_back(sample_t'(y));
            pending_sat.push_back(clipped);
        endfunction

        function void note_transfer(cmd_t cmd, sample_t x, order_t idx, coef_t c);
            if (cmd == CMD_COEF) begin
                if (idx <= MAX_ORDER) begin
                    kcoef[idx] = c;
                end
            end else begin
                filter_sample(x);
            end
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(sample_t y, logic sat);
            sample_t exp_y;
            bit      exp_sat;
            if (pending_out.size() == 0) begin
                note_error($sformatf("unexpected result: out %0d sat %0b", y, sat));
                return;
            end
            exp_y   = pending_out.pop_front();
            exp_sat = pending_sat.pop_front();
            if (y !== exp_y || sat !== exp_sat) begin
                note_error($sformatf("result error: expected out %0d sat %0b, got out %0d sat %0b",
                                     exp_y, exp_sat, y, sat));
            end
        endfunction
    endclass

    logic    aclk         = 1'b0;
    logic    aresetn      = 1'b0;
    logic    cfg_we       = 1'b0;
    order_t  cfg_wdata    = '0;
    logic    s_valid      = 1'b0;
    logic    s_ready;
    logic    s_command    = 1'b0;
    sample_t s_sample_in  = '0;
    order_t  s_coef_index = '0;
    coef_t   s_coef_value = '0;
    logic    m_valid;
    logic    m_ready      = 1'b0;
    sample_t m_sample_out;
    logic    m_saturated;

    bit idle_on  = 1'b1;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int cycles     = 0;

    lattice_scoreboard sb = new();

    all_zero_lattice_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_saturated  (m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("all_zero_lattice_filter: mismatch");
            $finish;
        end
    end

    // both transfers sampled with pre-edge values
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_transfer(cmd_t'(s_command), s_sample_in, s_coef_index, s_coef_value);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_sample_out, m_saturated);
        end
    end

    initial begin : result_side
        int unsigned stall, run;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = 0;
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
            repeat (run) @(posedge aclk);
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(OUT_MAX);
            1: return sample_t'(OUT_MIN);
            2: return sample_t'(int'($urandom_range(0, 512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef(bit wild);
        if (wild) begin
            case ($urandom_range(0, 5))
                0: return coef_t'(COEF_MAX);
                1: return coef_t'(COEF_MIN);
                default: return coef_t'($urandom);
            endcase
        end
        return coef_t'(int'($urandom_range(0, 32000)) - 16000);
    endfunction

    task automatic sender_gap();
        if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_item(cmd_t cmd, sample_t x, order_t idx, coef_t c);
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_sample_in  <= x;
        s_coef_index <= idx;
        s_coef_value <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_FILTER || idx <= MAX_ORDER) begin
            items_sent++;
        end
        sender_gap();
    endtask

    // unused fields carry random junk
    task automatic send_filter(sample_t x);
        send_item(CMD_FILTER, x, order_t'($urandom), coef_t'($urandom));
    endtask

    task automatic send_coef(order_t idx, coef_t c);
        send_item(CMD_COEF, sample_t'($urandom), idx, c);
    endtask

    // coefficient transfers leave no result, so allow a full filter pass to drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (MAX_ORDER + 4) @(posedge aclk);
    endtask

    task automatic write_order(order_t v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_order(v);
    endtask

    initial begin : stimulus
        int unsigned new_order, cur_order, n, phase;
        bit wild;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table still all zero after reset
        send_filter(sample_t'(OUT_MAX));
        send_coef(order_t'(0), coef_t'(UNITY));
        // slots past the table are dropped
        send_coef(order_t'(17), coef_t'(COEF_MIN));
        send_coef(order_t'(31), coef_t'(COEF_MAX));
        send_coef(order_t'(1), coef_t'(COEF_MAX));
        send_coef(order_t'(2), coef_t'(UNITY / 2));
        send_coef(order_t'(16), coef_t'(COEF_MIN));
        send_filter(sample_t'(OUT_MIN));
        send_filter(sample_t'(OUT_MAX));
        send_filter(sample_t'(0));
        send_filter(sample_t'(-1));
        send_filter(sample_t'(1));
        send_coef(order_t'(3), coef_t'(-UNITY / 4));
        send_filter(sample_t'(OUT_MAX));
        settle();
        write_order(order_t'(0));
        send_coef(order_t'(0), coef_t'(COEF_MIN));
        send_filter(sample_t'(OUT_MAX));
        send_filter(sample_t'(OUT_MIN));
        send_filter(sample_t'(1));
        settle();
        // above the table size, clamps to full order
        write_order(order_t'(31));
        send_filter(sample_t'(OUT_MAX));
        send_filter(sample_t'(12345));
        cur_order = MAX_ORDER;

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent > ITEM_GOAL - 200) begin
                idle_on = 1'b0;
            end
            quiet = ($urandom_range(0, 4) == 0);
            case (phase)
                0: new_order = MAX_ORDER;
                1: new_order = MAX_ORDER;
                2: new_order = 0;
                3: new_order = 31;
                4: new_order = 17;
                5: new_order = 1;
                default: begin
                    new_order = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 12);
                end
            endcase
            // some frames reload coefficients without touching the order or delay line
            if (phase < 6 || phase % 4 != 3) begin
                settle();
                write_order(order_t'(new_order));
                cur_order = (new_order > MAX_ORDER) ? MAX_ORDER : new_order;
            end
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            wild = ($urandom_range(0, 4) == 0);
            send_coef(order_t'(0), wild ? pick_coef(1'b1)
                              : coef_t'(int'($urandom_range(UNITY - 8000, UNITY + 8000))));
            for (int i = 1; i <= cur_order; i++) begin
                send_coef(order_t'(i), pick_coef(wild));
            end
            n = $urandom_range(8, 40);
            repeat (n) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_coef(order_t'($urandom_range(0, 31)), pick_coef(1'b1));
                end else begin
                    send_filter(pick_sample());
                end
            end
            phase++;
        end

        settle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("all_zero_lattice_filter: match");
        end else begin
            $display("all_zero_lattice_filter: mismatch");
        end
        $finish;
    end

endmodule
